// ===== rtl/ket_pkg.sv =====
`timescale 1ns / 1ps

package ket_pkg;

  // Default number of table slots.
  localparam int unsigned KetTableDepth = 512;

  // Field widths.
  localparam int unsigned KeyW   = 32;
  localparam int unsigned TeamW  = 32;
  localparam int unsigned DateW  = 27;
  localparam int unsigned StampW = 64;
  localparam int unsigned TtlW   = 32;

  // Reset value of the time-to-live register.
  localparam logic [TtlW-1:0] TtlReset = TtlW'(60000);

  // Function codes.
  localparam logic FuncRecord = 1'b0;
  localparam logic FuncQuery  = 1'b1;

  // One table slot as it is held in the memory.
  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [TeamW-1:0]  team;
    logic [DateW-1:0]  date;
    logic [StampW-1:0] stamp;
  } entry_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFinish
  } state_e;

endpackage

// ===== rtl/ket_ram.sv =====
`timescale 1ns / 1ps

module ket_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/keyed_expiry_table_ring_fill.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Signals
// command   in         start, busy, func_i, player_id_i, team_id_i, date_i, now_ms_i
// result    out        done_o, found_o, found_team_o
// config    in         cfg_valid_i, cfg_ready_o, cfg_data_i (ttl in ms)
//
// Every command that is not dropped scans all TableDepth slots through the single memory
// read port, one slot per cycle, and holds busy until the scan is through.
// A record item with a zero key, team or date is dropped on acceptance; busy stays low.
// No clearing pass follows reset: a fill count marks slots never written as empty.
// A query result is shown for exactly one cycle on done_o; the receiver cannot stall.
module keyed_expiry_table_ring_fill
  import ket_pkg::*;
#(
  parameter int unsigned TableDepth = KetTableDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              func_i,
  input  logic [KeyW-1:0]   player_id_i,
  input  logic [TeamW-1:0]  team_id_i,
  input  logic [DateW-1:0]  date_i,
  input  logic [StampW-1:0] now_ms_i,
  output logic              done_o,
  output logic              found_o,
  output logic [TeamW-1:0]  found_team_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [TtlW-1:0]   cfg_data_i
);

  localparam int unsigned IdxW  = $clog2(TableDepth);
  localparam int unsigned FillW = $clog2(TableDepth + 1);
  localparam int unsigned CntW  = $clog2(TableDepth + 2);
  localparam logic [CntW-1:0]  LastCnt  = CntW'(TableDepth + 1);
  localparam logic [CntW-1:0]  IssueEnd = CntW'(TableDepth);
  localparam logic [FillW-1:0] FillFull = FillW'(TableDepth);
  localparam logic [IdxW-1:0]  LastIdx  = IdxW'(TableDepth - 1);

  state_e state_q, state_d;

  logic [TtlW-1:0]   ttl_q;
  logic [IdxW-1:0]   next_slot_q;
  logic [FillW-1:0]  fill_q;
  logic [CntW-1:0]   cnt_q;

  // Command word held for the whole scan.
  logic              func_q;
  logic [KeyW-1:0]   key_q;
  logic [TeamW-1:0]  team_q;
  logic [DateW-1:0]  date_q;
  logic [StampW-1:0] now_q;
  logic              query_ok_q;

  // Scan pipeline.
  logic              p1_vld_q;
  logic [IdxW-1:0]   p1_idx_q;
  logic              p2_hit_q;
  logic [IdxW-1:0]   p2_idx_q;
  logic [StampW-1:0] p2_stamp_q;
  logic [TeamW-1:0]  p2_team_q;

  // Accumulated results.
  logic              best_hit_q;
  logic [StampW-1:0] best_stamp_q;
  logic [TeamW-1:0]  best_team_q;
  logic              rec_hit_q;
  logic [IdxW-1:0]   rec_idx_q;

  logic              accept;
  logic              drop;
  logic              issue;
  logic              slot_valid;
  logic              hit;
  logic [StampW:0]   age;
  logic              we;
  logic [IdxW-1:0]   waddr;
  entry_t            wentry;
  entry_t            rentry;
  logic [$bits(entry_t)-1:0] rdata;

  assign accept = start && !busy;
  assign drop   = (func_i == FuncRecord) &&
                  ((player_id_i == '0) || (team_id_i == '0) || (date_i == '0));
  assign issue  = (state_q == StScan) && (cnt_q < IssueEnd);

  ket_ram #(
    .Width ($bits(entry_t)),
    .Depth (TableDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wentry),
    .raddr_i (cnt_q[IdxW-1:0]),
    .rdata_o (rdata)
  );

  assign rentry = entry_t'(rdata);

  // Match test on the slot just read; slots beyond the fill count are empty.
  always_comb begin
    slot_valid = ({1'b0, p1_idx_q} < (IdxW + 1)'(fill_q));
    age        = {1'b0, now_q} - {1'b0, rentry.stamp};
    if (func_q == FuncQuery) begin
      hit = query_ok_q && slot_valid && (rentry.key == key_q) &&
            (rentry.team != '0) && (rentry.date == date_q) &&
            (rentry.stamp != '0) && !age[StampW] &&
            (age[StampW-1:0] <= {{(StampW - TtlW){1'b0}}, ttl_q});
    end else begin
      hit = slot_valid && (rentry.key == key_q) && (rentry.team == team_q);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept && !drop) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (cnt_q == LastCnt) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Outputs and memory write control.
  always_comb begin
    busy   = 1'b0;
    done_o = 1'b0;
    we     = 1'b0;
    waddr  = next_slot_q;
    case (state_q)
      StIdle: begin
        busy = 1'b0;
      end
      StScan: begin
        busy = 1'b1;
      end
      StFinish: begin
        busy   = 1'b1;
        done_o = (func_q == FuncQuery);
        we     = (func_q == FuncRecord);
        waddr  = rec_hit_q ? rec_idx_q : next_slot_q;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  assign wentry.key   = key_q;
  assign wentry.team  = team_q;
  assign wentry.date  = date_q;
  assign wentry.stamp = now_q;

  assign found_o      = best_hit_q;
  assign found_team_o = best_team_q;
  assign cfg_ready_o  = 1'b1;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ttl_q       <= TtlReset;
      next_slot_q <= '0;
      fill_q      <= '0;
      cnt_q       <= '0;
      p1_vld_q    <= 1'b0;
      p2_hit_q    <= 1'b0;
      best_hit_q  <= 1'b0;
      rec_hit_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      p1_vld_q <= issue;
      p2_hit_q <= p1_vld_q && hit;
      if (cfg_valid_i && cfg_ready_o) begin
        ttl_q <= cfg_data_i;
      end
      if (accept) begin
        cnt_q      <= '0;
        best_hit_q <= 1'b0;
        rec_hit_q  <= 1'b0;
      end else if (state_q == StScan) begin
        cnt_q <= cnt_q + 1'b1;
      end
      // Keep the newest match; a tie goes to the later slot.
      if (p2_hit_q && (func_q == FuncQuery) &&
          (!best_hit_q || (p2_stamp_q >= best_stamp_q))) begin
        best_hit_q <= 1'b1;
      end
      if (p2_hit_q && (func_q == FuncRecord) && !rec_hit_q) begin
        rec_hit_q <= 1'b1;
      end
      // A new entry takes the ring slot and grows the fill count.
      if ((state_q == StFinish) && (func_q == FuncRecord) && !rec_hit_q) begin
        next_slot_q <= (next_slot_q == LastIdx) ? '0 : next_slot_q + 1'b1;
        if (fill_q != FillFull) begin
          fill_q <= fill_q + 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q       <= func_i;
      key_q        <= player_id_i;
      team_q       <= team_id_i;
      date_q       <= date_i;
      now_q        <= now_ms_i;
      query_ok_q   <= (player_id_i != '0) && (date_i != '0);
      best_stamp_q <= '0;
      best_team_q  <= '0;
    end else if (p2_hit_q && (func_q == FuncQuery) &&
                 (!best_hit_q || (p2_stamp_q >= best_stamp_q))) begin
      best_stamp_q <= p2_stamp_q;
      best_team_q  <= p2_team_q;
    end
    p1_idx_q   <= cnt_q[IdxW-1:0];
    p2_idx_q   <= p1_idx_q;
    p2_stamp_q <= rentry.stamp;
    p2_team_q  <= rentry.team;
    if (p2_hit_q && (func_q == FuncRecord) && !rec_hit_q) begin
      rec_idx_q <= p2_idx_q;
    end
  end

endmodule

// ===== tb/keyed_expiry_table_ring_fill_test.sv =====
`timescale 1ns / 1ps

module keyed_expiry_table_ring_fill_test;
  import ket_pkg::*;

  localparam int unsigned Depth      = KetTableDepth;
  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned PhaseItems = 225;

  // One command word as the driver presents it, with the idle time before it.
  typedef struct {
    logic              func;
    logic [KeyW-1:0]   player;
    logic [TeamW-1:0]  team;
    logic [DateW-1:0]  date;
    logic [StampW-1:0] now;
    int unsigned       gap;
    bit                gap_idle;
  } ket_cmd_t;

  // One lookup answer.
  typedef struct {
    logic             found;
    logic [TeamW-1:0] team;
  } lookup_t;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              start        = 1'b0;
  logic              busy;
  logic              func_i       = FuncRecord;
  logic [KeyW-1:0]   player_id_i  = '0;
  logic [TeamW-1:0]  team_id_i    = '0;
  logic [DateW-1:0]  date_i       = '0;
  logic [StampW-1:0] now_ms_i     = '0;
  logic              done_o;
  logic              found_o;
  logic [TeamW-1:0]  found_team_o;
  logic              cfg_valid_i  = 1'b0;
  logic              cfg_ready_o;
  logic [TtlW-1:0]   cfg_data_i   = '0;

  keyed_expiry_table_ring_fill i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .func_i      (func_i),
    .player_id_i (player_id_i),
    .team_id_i   (team_id_i),
    .date_i      (date_i),
    .now_ms_i    (now_ms_i),
    .done_o      (done_o),
    .found_o     (found_o),
    .found_team_o(found_team_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Free-running clock, 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predicted contents of the expiry table, the fill pointer and the TTL.
  logic [KeyW-1:0]   ent_key   [Depth];
  logic [TeamW-1:0]  ent_team  [Depth];
  logic [DateW-1:0]  ent_date  [Depth];
  logic [StampW-1:0] ent_stamp [Depth];
  int unsigned       fill_ptr = 0;
  logic [TtlW-1:0]   ttl_ms   = TtlReset;

  initial begin
    for (int i = 0; i < Depth; i++) begin
      ent_key[i]   = '0;
      ent_team[i]  = '0;
      ent_date[i]  = '0;
      ent_stamp[i] = '0;
    end
  end

  ket_cmd_t    cmd_q[$];
  lookup_t     lookup_q[$];
  ket_cmd_t    recent_q[$];
  int unsigned n_pushed   = 0;
  int unsigned n_accepted = 0;
  int unsigned errors     = 0;
  int unsigned cycle_count = 0;
  logic [StampW-1:0] sim_ms = '0;

  // Applies an accepted word to the predicted table; a lookup queues its answer.
  function automatic void apply_cmd(input ket_cmd_t c);
    logic [StampW-1:0] best_stamp;
    lookup_t           ans;
    int unsigned       slot;
    if (c.func == FuncRecord) begin
      if (c.player == '0 || c.team == '0 || c.date == '0) return;
      // An existing key and team pair is refreshed in place.
      for (int i = 0; i < Depth; i++) begin
        if (ent_key[i] == c.player && ent_team[i] == c.team) begin
          ent_date[i]  = c.date;
          ent_stamp[i] = c.now;
          return;
        end
      end
      slot = (fill_ptr >= Depth) ? 0 : fill_ptr;
      ent_key[slot]   = c.player;
      ent_team[slot]  = c.team;
      ent_date[slot]  = c.date;
      ent_stamp[slot] = c.now;
      fill_ptr = (slot + 1) % Depth;
    end else begin
      best_stamp = '0;
      ans.team   = '0;
      if (c.player != '0 && c.date != '0) begin
        for (int i = 0; i < Depth; i++) begin
          if (ent_key[i] != c.player || ent_team[i] == '0 || ent_date[i] != c.date) continue;
          if (ent_stamp[i] == '0 || c.now < ent_stamp[i]) continue;
          if (c.now - ent_stamp[i] > {32'd0, ttl_ms}) continue;
          // The later slot wins a tie on the stamp.
          if (ent_stamp[i] >= best_stamp) begin
            best_stamp = ent_stamp[i];
            ans.team   = ent_team[i];
          end
        end
      end
      ans.found = (ans.team != '0);
      lookup_q.push_back(ans);
    end
  endfunction

  // Driver: holds start until the word is taken, then presents the next one.
  ket_cmd_t    live;
  ket_cmd_t    nxt;
  bit          loaded   = 1'b0;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin : drive
    logic took;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      took = start && !busy;
      if (took) begin
        apply_cmd(live);
        n_accepted++;
      end
      if (!start || took) begin
        if (!loaded && cmd_q.size() > 0) begin
          nxt      = cmd_q.pop_front();
          loaded   = 1'b1;
          gap_left = nxt.gap;
        end
        if (loaded && gap_left > 0) begin
          // Some gaps only count down once the block has gone idle.
          if (!nxt.gap_idle || !busy) gap_left--;
          start <= 1'b0;
        end else if (loaded) begin
          live        = nxt;
          loaded      = 1'b0;
          start       <= 1'b1;
          func_i      <= nxt.func;
          player_id_i <= nxt.player;
          team_id_i   <= nxt.team;
          date_i      <= nxt.date;
          now_ms_i    <= nxt.now;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest answer.
  always @(posedge clk_i) begin : watch
    lookup_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (lookup_q.size() == 0) begin
        $error("unexpected result word: found %0d found_team %0h", found_o, found_team_o);
        errors++;
      end else begin
        want = lookup_q.pop_front();
        if (found_o !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, found_o);
          errors++;
        end
        if (found_team_o !== want.team) begin
          $error("found_team: expected %0h, actual %0h", want.team, found_team_o);
          errors++;
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void add_cmd(input logic f, input logic [KeyW-1:0] k,
                                  input logic [TeamW-1:0] t, input logic [DateW-1:0] d,
                                  input logic [StampW-1:0] n);
    ket_cmd_t c;
    c.func     = f;
    c.player   = k;
    c.team     = t;
    c.date     = d;
    c.now      = n;
    c.gap      = 0;
    c.gap_idle = 1'b0;
    cmd_q.push_back(c);
    n_pushed++;
  endfunction

  // Keys come mostly from a small pool so that refreshes and hits occur.
  function automatic logic [KeyW-1:0] pick_key();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 85) return KeyW'($urandom_range(12, 1));
    if (roll < 95) return $urandom;
    if (roll < 98) return '1;
    return '0;
  endfunction

  function automatic logic [TeamW-1:0] pick_team();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 85) return TeamW'($urandom_range(1000, 1));
    if (roll < 97) return $urandom;
    return '1;
  endfunction

  function automatic logic [DateW-1:0] pick_date();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 80) begin
      case ($urandom_range(3, 0))
        0:       return DateW'(20240101);
        1:       return DateW'(20240102);
        2:       return DateW'(20251231);
        default: return DateW'(99991231);
      endcase
    end
    return DateW'($urandom_range(99991231, 1));
  endfunction

  // Builds random words until enough have been queued that the block acts on.
  task automatic gen_random(input int unsigned count, input bit with_gaps);
    ket_cmd_t    c;
    ket_cmd_t    r;
    int unsigned made;
    int unsigned roll;
    made = 0;
    while (made < count) begin
      // The time mostly creeps forward, with occasional jumps and reversals.
      roll = $urandom_range(99, 0);
      if (roll < 40)      sim_ms = sim_ms + $urandom_range(3, 0);
      else if (roll < 85) sim_ms = sim_ms + $urandom_range(2000, 0);
      else if (roll < 93) sim_ms = sim_ms + $urandom_range(100000, 0);
      else if (roll < 96) sim_ms = sim_ms - $urandom_range(5000, 1);
      else if (roll < 98) sim_ms = {$urandom, $urandom};
      c.now = (roll >= 98) ? '0 : sim_ms;
      roll = $urandom_range(99, 0);
      if ($urandom_range(99, 0) < 62) begin
        c.func = FuncRecord;
        if (roll < 18 && recent_q.size() > 0) begin
          r        = recent_q[$urandom_range(recent_q.size() - 1, 0)];
          c.player = r.player;
          c.team   = r.team;
          c.date   = pick_date();
        end else begin
          c.player = pick_key();
          c.team   = pick_team();
          c.date   = pick_date();
          if (roll < 24) begin
            case ($urandom_range(2, 0))
              0:       c.player = '0;
              1:       c.team   = '0;
              default: c.date   = '0;
            endcase
          end
        end
        if (c.player != '0 && c.team != '0 && c.date != '0) begin
          recent_q.push_back(c);
          if (recent_q.size() > 24) void'(recent_q.pop_front());
        end
      end else begin
        c.func = FuncQuery;
        c.team = $urandom;
        if (roll < 65 && recent_q.size() > 0) begin
          r        = recent_q[$urandom_range(recent_q.size() - 1, 0)];
          c.player = r.player;
          c.date   = r.date;
        end else begin
          c.player = pick_key();
          c.date   = (roll > 96) ? '0 : pick_date();
        end
      end
      c.gap      = 0;
      c.gap_idle = 1'b0;
      if (with_gaps && $urandom_range(3, 0) == 0) begin
        c.gap      = $urandom_range(7, 1);
        c.gap_idle = $urandom_range(1, 0);
      end
      cmd_q.push_back(c);
      n_pushed++;
      if (!(c.func == FuncRecord && (c.player == '0 || c.team == '0 || c.date == '0))) made++;
    end
  endtask

  // Waits for every word to be taken and every answer to arrive, then for a full scan.
  task automatic wait_quiet();
    int unsigned waited;
    waited = 0;
    while (n_accepted != n_pushed) @(negedge clk_i);
    while (lookup_q.size() > 0 && waited < 4 * Depth) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (Depth + 10) @(negedge clk_i);
  endtask

  task automatic write_ttl(input logic [TtlW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    ttl_ms = value;
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Sequence: directed words, then random phases under several TTL settings.
  initial begin
    // Empty table, ignored records, the TTL boundary and a clock going backwards.
    add_cmd(FuncQuery,  32'd1, 32'd0, 27'd20240101, 64'd1000);
    add_cmd(FuncRecord, 32'd0, 32'd5, 27'd20240101, 64'd1000);
    add_cmd(FuncRecord, 32'd1, 32'd0, 27'd20240101, 64'd1000);
    add_cmd(FuncRecord, 32'd1, 32'd5, 27'd0,        64'd1000);
    add_cmd(FuncRecord, 32'd1, 32'd5, 27'd20240101, 64'd1000);
    add_cmd(FuncQuery,  32'd1, 32'd0, 27'd20240101, 64'd1000);
    add_cmd(FuncQuery,  32'd1, 32'd0, 27'd20240101, 64'd61000);
    add_cmd(FuncQuery,  32'd1, 32'd0, 27'd20240101, 64'd61001);
    add_cmd(FuncQuery,  32'd1, 32'd0, 27'd20240101, 64'd999);
    add_cmd(FuncQuery,  32'd0, 32'd0, 27'd20240101, 64'd1000);
    add_cmd(FuncQuery,  32'd1, 32'd0, 27'd0,        64'd1000);
    add_cmd(FuncQuery,  32'd1, 32'd0, 27'd20240102, 64'd1000);
    // An entry stamped at time zero never matches.
    add_cmd(FuncRecord, 32'd2, 32'd7, 27'd20240101, 64'd0);
    add_cmd(FuncQuery,  32'd2, 32'd0, 27'd20240101, 64'd10);
    // Newest entry wins, a tie goes to the later slot, then a refresh.
    add_cmd(FuncRecord, 32'd1, 32'd6, 27'd20240101, 64'd2000);
    add_cmd(FuncQuery,  32'd1, 32'd0, 27'd20240101, 64'd2500);
    add_cmd(FuncRecord, 32'd1, 32'd9, 27'd20240101, 64'd2000);
    add_cmd(FuncQuery,  32'd1, 32'd0, 27'd20240101, 64'd2500);
    add_cmd(FuncRecord, 32'd1, 32'd5, 27'd20240101, 64'd3000);
    add_cmd(FuncQuery,  32'd1, 32'd0, 27'd20240101, 64'd3000);
    // Field extremes.
    add_cmd(FuncRecord, '1, '1, 27'd99991231, '1);
    add_cmd(FuncQuery,  '1, '0, 27'd99991231, '1);
    add_cmd(FuncQuery,  32'd1, '1, 27'd20240101, 64'd3001);
    sim_ms = 64'd5000;
    gen_random(PhaseItems, 1'b1);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_quiet();
    write_ttl('0);
    gen_random(PhaseItems, 1'b1);
    wait_quiet();
    write_ttl('1);
    gen_random(PhaseItems, 1'b1);
    wait_quiet();
    write_ttl(TtlW'(37));
    gen_random(PhaseItems, 1'b1);
    wait_quiet();
    write_ttl(TtlReset);
    // Last part runs without idling.
    gen_random(PhaseItems, 1'b0);
    wait_quiet();
    if (lookup_q.size() > 0) begin
      $error("found: %0d lookup answers never arrived", lookup_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ket_pkg.sv
rtl/ket_ram.sv
rtl/keyed_expiry_table_ring_fill.sv
tb/keyed_expiry_table_ring_fill_test.sv
